[rtl/mlfq_pkg.sv]
// Package with the constants, codes and transaction types of the feedback queue scheduler.
package mlfq_pkg;

    localparam int NUM_PROCS  = 16;
    localparam int BURST_BITS = 16;
    localparam int LEVELS     = 4;
    localparam int LVL_W      = 2;
    localparam int SLICE_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int PTR_W      = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int CNT_W      = $clog2(NUM_PROCS + 1);
    localparam int QRAM_DEPTH = LEVELS * (2 ** PTR_W);
    localparam int QRAM_AW    = LVL_W + PTR_W;

    localparam logic [1:0] KIND_ARRIVAL = 2'd0;
    localparam logic [1:0] KIND_IO_DONE = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    localparam logic [1:0] EVT_NONE    = 2'd0;
    localparam logic [1:0] EVT_PREEMPT = 2'd1;
    localparam logic [1:0] EVT_TO_IO   = 2'd2;
    localparam logic [1:0] EVT_FINISH  = 2'd3;

    localparam logic [LVL_W-1:0] LVL_TOP    = 2'd0;
    localparam logic [LVL_W-1:0] LVL_ONE    = 2'd1;
    localparam logic [LVL_W-1:0] LVL_TWO    = 2'd2;
    localparam logic [LVL_W-1:0] LVL_BOTTOM = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_ZERO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_ONE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_TWO  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  proc_id;
        logic [2:0]  start_level;
        logic [15:0] cpu_burst;
        logic        final_burst;
    } t_in_item;

    typedef struct packed {
        logic       status;
        logic       run_valid;
        logic [3:0] run_id;
        logic [1:0] event_res;
        logic [1:0] new_level;
    } t_out_item;

    typedef struct packed {
        logic [LVL_W-1:0]      level;
        logic [BURST_BITS-1:0] burst;
        logic                  last;
    } t_proc_rec;

endpackage

[rtl/mlfq_ram.sv]
// Generic single write port, single read port RAM with a registered read.
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/multilevel_feedback_queue_scheduler.sv]
// Top level of the four-level feedback queue scheduler with its queue and process memories.
//
//  Channel  Direction  Handshake              Payload
//  in       to block   i_in_valid/o_in_stall  i_in_data (t_in_item)
//  out      from block o_out_valid/i_out_stall o_out_data (t_out_item)
//  cfg      to block   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Arrivals, I/O completions and ticks of a busy CPU go straight to execution; a tick that
// dispatches first waits for the queue memory read, which must return the process id before the
// process memory can be read. Both memories have a registered read.
// Reset clears the queue pointers and counts and the CPU state, and loads the slice registers
// with their default lengths.
// A result waits in the output register while the output is stalled; the next transaction
// is accepted meanwhile, and its result is held until the output register frees up.
module multilevel_feedback_queue_scheduler
    import mlfq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SLICE_W-1:0]   i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_QWAIT,
        S_EXEC,
        S_HOLD
    } t_state;

    localparam int PREC_W = $bits(t_proc_rec);

    t_state              r_state;
    t_in_item            r_item;
    t_out_item           r_res;
    t_out_item           r_out_data;
    logic                r_out_valid;
    logic [SLICE_W-1:0]  r_slice_zero;
    logic [SLICE_W-1:0]  r_slice_one;
    logic [SLICE_W-1:0]  r_slice_two;
    logic [PTR_W-1:0]    r_head [LEVELS];
    logic [PTR_W-1:0]    r_tail [LEVELS];
    logic [CNT_W-1:0]    r_count [LEVELS];
    logic                r_busy;
    logic [PTR_W-1:0]    r_owner;
    logic [SLICE_W-1:0]  r_slice_left;
    logic                r_unlimited;

    logic                in_acc;
    logic                out_free;
    logic                any_q;
    logic [LVL_W-1:0]    disp_lvl;
    logic [SLICE_W-1:0]  disp_slice;
    logic                q_rd_en;
    logic [QRAM_AW-1:0]  q_rd_addr;
    logic [PTR_W-1:0]    q_rd_data;
    logic                q_wr_en;
    logic [QRAM_AW-1:0]  q_wr_addr;
    logic                p_rd_en;
    logic [PTR_W-1:0]    p_rd_addr;
    logic [PREC_W-1:0]   p_rd_data;
    logic                p_wr_en;
    logic [PTR_W-1:0]    p_wr_addr;
    t_proc_rec           p_wr_rec;
    t_proc_rec           rec;
    logic                enq_req;
    logic [LVL_W-1:0]    enq_lvl;
    logic [PTR_W-1:0]    enq_pid;
    logic                enq_full;
    logic [LVL_W-1:0]    io_lvl;
    logic                item_ok;
    logic [BURST_BITS-1:0] load_burst;
    logic [BURST_BITS-1:0] burst_n;
    logic                burst_end;
    logic                slice_exp;
    logic [LVL_W-1:0]    lvl_n;
    t_out_item           n_res;
    logic                n_busy;
    logic [SLICE_W-1:0]  n_slice_left;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(NUM_PROCS - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        any_q    = 1'b0;
        disp_lvl = LVL_BOTTOM;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_count[l] != '0) begin
                any_q    = 1'b1;
                disp_lvl = LVL_W'(l);
            end
        end
        case (disp_lvl)
            LVL_TOP: disp_slice = r_slice_zero;
            LVL_ONE: disp_slice = r_slice_one;
            default: disp_slice = r_slice_two;
        endcase
        if (disp_slice == '0) begin
            disp_slice = SLICE_W'(1);
        end
    end

    always_comb begin
        q_rd_en   = in_acc && (i_in_data.kind == KIND_TICK) && !r_busy && any_q;
        q_rd_addr = {disp_lvl, r_head[disp_lvl]};

        p_rd_en   = 1'b0;
        p_rd_addr = PTR_W'(i_in_data.proc_id);
        if (r_state == S_QWAIT) begin
            p_rd_en   = 1'b1;
            p_rd_addr = q_rd_data;
        end else if (in_acc) begin
            if (i_in_data.kind == KIND_IO_DONE) begin
                p_rd_en = 1'b1;
            end else if (i_in_data.kind == KIND_TICK && r_busy) begin
                p_rd_en   = 1'b1;
                p_rd_addr = r_owner;
            end
        end
    end

    always_comb begin
        rec        = t_proc_rec'(p_rd_data);
        load_burst = BURST_BITS'(r_item.cpu_burst);
        if (load_burst == '0) begin
            load_burst = BURST_BITS'(1);
        end
        io_lvl = rec.level;
        if (rec.level == LVL_ONE || rec.level == LVL_TWO) begin
            io_lvl = rec.level - 1'b1;
        end
        item_ok = (32'(r_item.proc_id) < NUM_PROCS)
                  && !(r_item.kind == KIND_ARRIVAL && r_item.start_level > 3'(LVL_BOTTOM));

        burst_n      = (rec.burst != '0) ? rec.burst - 1'b1 : '0;
        burst_end    = (burst_n == '0);
        n_slice_left = r_slice_left;
        slice_exp    = 1'b0;
        if (!r_unlimited) begin
            n_slice_left = (r_slice_left != '0) ? r_slice_left - 1'b1 : '0;
            slice_exp    = (n_slice_left == '0);
        end
        lvl_n = (slice_exp && rec.level != LVL_BOTTOM) ? rec.level + 1'b1 : rec.level;

        n_res    = '0;
        n_busy   = r_busy;
        enq_req  = 1'b0;
        enq_lvl  = r_item.start_level[LVL_W-1:0];
        enq_pid  = PTR_W'(r_item.proc_id);
        p_wr_en  = 1'b0;
        p_wr_addr = PTR_W'(r_item.proc_id);
        p_wr_rec = '{level: enq_lvl, burst: load_burst, last: r_item.final_burst};

        if (r_state == S_EXEC) begin
            case (r_item.kind)
                KIND_ARRIVAL, KIND_IO_DONE: begin
                    if (r_item.kind == KIND_IO_DONE) begin
                        enq_lvl = io_lvl;
                    end
                    p_wr_rec.level = enq_lvl;
                    if (!item_ok) begin
                        n_res.status = 1'b1;
                    end else if (r_count[enq_lvl] == CNT_W'(NUM_PROCS)) begin
                        n_res.status = 1'b1;
                    end else begin
                        enq_req         = 1'b1;
                        p_wr_en         = 1'b1;
                        n_res.new_level = enq_lvl;
                    end
                end
                KIND_TICK: begin
                    if (r_busy) begin
                        p_wr_en         = 1'b1;
                        p_wr_addr       = r_owner;
                        p_wr_rec        = '{level: lvl_n, burst: burst_n, last: rec.last};
                        n_res.run_valid = 1'b1;
                        n_res.run_id    = 4'(r_owner);
                        n_res.new_level = lvl_n;
                        if (burst_end) begin
                            n_res.event_res = rec.last ? EVT_FINISH : EVT_TO_IO;
                            n_busy          = 1'b0;
                        end else if (slice_exp) begin
                            n_res.event_res = EVT_PREEMPT;
                            n_busy          = 1'b0;
                            enq_req         = 1'b1;
                            enq_lvl         = lvl_n;
                            enq_pid         = r_owner;
                        end
                    end
                end
                default: begin
                    n_res = '0;
                end
            endcase
        end

        enq_full  = (r_count[enq_lvl] == CNT_W'(NUM_PROCS));
        q_wr_en   = enq_req && !enq_full;
        q_wr_addr = {enq_lvl, r_tail[enq_lvl]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_item       <= '0;
            r_res        <= '0;
            r_out_data   <= '0;
            r_out_valid  <= 1'b0;
            r_slice_zero <= SLICE_W'(1);
            r_slice_one  <= SLICE_W'(2);
            r_slice_two  <= SLICE_W'(4);
            r_busy       <= 1'b0;
            r_owner      <= '0;
            r_slice_left <= '0;
            r_unlimited  <= 1'b0;
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SLICE_ZERO: r_slice_zero <= i_cfg_data;
                    CFG_SLICE_ONE:  r_slice_one  <= i_cfg_data;
                    CFG_SLICE_TWO:  r_slice_two  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if ((r_state == S_EXEC || r_state == S_HOLD) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (q_rd_en) begin
                r_head[disp_lvl]  <= ptr_inc(r_head[disp_lvl]);
                r_count[disp_lvl] <= r_count[disp_lvl] - 1'b1;
                r_busy            <= 1'b1;
                r_unlimited       <= (disp_lvl == LVL_BOTTOM);
                r_slice_left      <= (disp_lvl == LVL_BOTTOM) ? '0 : disp_slice;
            end
            if (q_wr_en) begin
                r_tail[enq_lvl]  <= ptr_inc(r_tail[enq_lvl]);
                r_count[enq_lvl] <= r_count[enq_lvl] + 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_item  <= i_in_data;
                        r_state <= q_rd_en ? S_QWAIT : S_EXEC;
                    end
                end
                S_QWAIT: begin
                    r_owner <= q_rd_data;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_busy <= n_busy;
                    if (r_item.kind == KIND_TICK && r_busy) begin
                        r_slice_left <= n_slice_left;
                    end
                    if (out_free) begin
                        r_out_data <= n_res;
                        r_state    <= S_IDLE;
                    end else begin
                        r_res   <= n_res;
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_out_data <= r_res;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    mlfq_ram #(
        .WIDTH (PTR_W),
        .DEPTH (QRAM_DEPTH)
    ) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (q_wr_en),
        .i_wr_addr (q_wr_addr),
        .i_wr_data (enq_pid),
        .i_rd_en   (q_rd_en),
        .i_rd_addr (q_rd_addr),
        .o_rd_data (q_rd_data)
    );

    mlfq_ram #(
        .WIDTH (PREC_W),
        .DEPTH (2 ** PTR_W)
    ) u_proc_ram (
        .i_clk     (i_clk),
        .i_wr_en   (p_wr_en),
        .i_wr_addr (p_wr_addr),
        .i_wr_data (p_wr_rec),
        .i_rd_en   (p_rd_en),
        .i_rd_addr (p_rd_addr),
        .o_rd_data (p_rd_data)
    );

endmodule
